[hdl/chunked_delta_order_bit_estimator_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the delta order estimator.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_DELTA_ORDER_BIT_ESTIMATOR_UNIT_MACROS_SVH
`define CHUNKED_DELTA_ORDER_BIT_ESTIMATOR_UNIT_MACROS_SVH

`ifndef SYNTH

`define CDOBE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define CDOBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CDOBE_ASSERT(lbl, clk, rst_n, prop, msg)

`define CDOBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[hdl/cdobe_pkg.sv]
// ----------------------------------------------------------------------------
// cdobe_pkg
// Types, constants and helper functions of the delta order estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package cdobe_pkg;

    localparam int CHUNK_LOG2_DEFAULT = 4;
    localparam int SAMPLE_W           = 8;
    localparam int DELTA_W            = 9;
    localparam int DDELTA_W           = 10;
    localparam int SPAN_W             = 11;
    localparam int BITS_W             = 4;
    localparam int TOTAL_W            = 32;
    localparam int SAMPLE_MIN         = -128;
    localparam int SAMPLE_MAX         = 127;
    localparam int Q_DEPTH            = 2;
    localparam int Q_AW               = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW               = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        ORDER_RAW    = 2'd0,
        ORDER_DELTA  = 2'd1,
        ORDER_DDELTA = 2'd2
    } t_order;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [DELTA_W-1:0]  delta;
        logic signed [DDELTA_W-1:0] ddelta;
        logic                       first;
        logic                       last;
    } t_front_item;

    // width of an unsigned span: index of highest set bit plus one
    function automatic logic [BITS_W-1:0] span_width(input logic [SPAN_W-1:0] span);
        logic [BITS_W-1:0] w;
        w = '0;
        for (int i = 0; i < SPAN_W; i++) begin
            if (span[i]) begin
                w = BITS_W'(i + 1);
            end
        end
        return w;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat8(input logic signed [DDELTA_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v < DDELTA_W'(SAMPLE_MIN)) begin
            r = SAMPLE_W'(SAMPLE_MIN);
        end else if (v > DDELTA_W'(SAMPLE_MAX)) begin
            r = SAMPLE_W'(SAMPLE_MAX);
        end else begin
            r = SAMPLE_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/cdobe_front.sv]
// ----------------------------------------------------------------------------
// cdobe_front
// Accepts samples, forms first and second differences and tags chunk edges.
// ----------------------------------------------------------------------------
`default_nettype none

module cdobe_front #(
    parameter int CHUNK_LOG2 = cdobe_pkg::CHUNK_LOG2_DEFAULT
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic signed [cdobe_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    output cdobe_pkg::t_front_item                     o_item,
    output logic                                       o_item_valid,
    input  wire logic                                  i_item_ready
);
    import cdobe_pkg::*;

    logic signed [SAMPLE_W-1:0] r_last_sample, n_last_sample;
    logic signed [DELTA_W-1:0]  r_last_delta, n_last_delta;
    logic [CHUNK_LOG2-1:0]      r_pos, n_pos;
    logic signed [DELTA_W-1:0]  delta;
    logic signed [DDELTA_W-1:0] ddelta;
    logic                       accept;

    assign o_ready      = i_item_ready;
    assign o_item_valid = i_valid;
    assign accept       = i_valid && i_item_ready;

    always_comb begin
        delta  = DELTA_W'(i_sample) - DELTA_W'(r_last_sample);
        ddelta = DDELTA_W'(delta) - DDELTA_W'(r_last_delta);

        o_item.sample = i_sample;
        o_item.delta  = delta;
        o_item.ddelta = ddelta;
        o_item.first  = (r_pos == '0);
        o_item.last   = (r_pos == '1);

        n_last_sample = r_last_sample;
        n_last_delta  = r_last_delta;
        n_pos         = r_pos;
        if (accept) begin
            n_last_sample = i_sample;
            n_last_delta  = delta;
            n_pos         = r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sample <= '0;
            r_last_delta  <= '0;
            r_pos         <= '0;
        end else begin
            r_last_sample <= n_last_sample;
            r_last_delta  <= n_last_delta;
            r_pos         <= n_pos;
        end
    end

endmodule

`default_nettype wire

[hdl/cdobe_queue.sv]
// ----------------------------------------------------------------------------
// cdobe_queue
// Short request queue between the front and back sections.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chunked_delta_order_bit_estimator_unit_macros.svh"

module cdobe_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire cdobe_pkg::t_front_item i_item,
    input  wire logic                   i_push_valid,
    output logic                        o_push_ready,
    output cdobe_pkg::t_front_item      o_item,
    output logic                        o_pop_valid,
    input  wire logic                   i_pop_ready
);
    import cdobe_pkg::*;

    t_front_item         r_mem [Q_DEPTH];
    logic [Q_AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0]     r_count, n_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != Q_CW'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `CDOBE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= Q_CW'(Q_DEPTH), "queue overfilled")
    `CDOBE_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + 1'b1, "queue count lost a push")

endmodule

`default_nettype wire

[hdl/cdobe_back.sv]
// ----------------------------------------------------------------------------
// cdobe_back
// Tracks chunk ranges, selects the narrowest order and keeps the bit total.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chunked_delta_order_bit_estimator_unit_macros.svh"

module cdobe_back #(
    parameter int CHUNK_LOG2 = cdobe_pkg::CHUNK_LOG2_DEFAULT
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire cdobe_pkg::t_front_item                i_item,
    input  wire logic                                  i_item_valid,
    output logic                                       o_item_ready,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic signed [cdobe_pkg::SAMPLE_W-1:0]      o_delta_out,
    output logic signed [cdobe_pkg::SAMPLE_W-1:0]      o_ddelta_out,
    output logic                                       o_chunk_end,
    output logic [cdobe_pkg::BITS_W-1:0]               o_chunk_bits,
    output logic [1:0]                                 o_chunk_order,
    output logic [cdobe_pkg::TOTAL_W-1:0]              o_total_bits
);
    import cdobe_pkg::*;

    logic signed [SAMPLE_W-1:0] r_raw_lo, n_raw_lo, r_raw_hi, n_raw_hi;
    logic signed [DELTA_W-1:0]  r_dl_lo, n_dl_lo, r_dl_hi, n_dl_hi;
    logic signed [DDELTA_W-1:0] r_dd_lo, n_dd_lo, r_dd_hi, n_dd_hi;
    logic [TOTAL_W-1:0]         r_total, n_total;
    logic                       r_valid, n_valid;
    logic signed [SAMPLE_W-1:0] r_delta_o, r_ddelta_o;
    logic                       r_end;
    logic [BITS_W-1:0]          r_bits, n_bits;
    t_order                     r_order, n_order;
    logic signed [SPAN_W-1:0]   span_raw, span_dl, span_dd;
    logic [BITS_W-1:0]          w_raw, w_dl, w_dd;
    logic [TOTAL_W:0]           sum;
    logic                       pop;

    assign pop          = i_item_valid && (!r_valid || i_ready);
    assign o_item_ready = !r_valid || i_ready;

    always_comb begin
        n_raw_lo = r_raw_lo;
        n_raw_hi = r_raw_hi;
        n_dl_lo  = r_dl_lo;
        n_dl_hi  = r_dl_hi;
        n_dd_lo  = r_dd_lo;
        n_dd_hi  = r_dd_hi;
        if (i_item.first) begin
            n_raw_lo = i_item.sample;
            n_raw_hi = i_item.sample;
            n_dl_lo  = i_item.delta;
            n_dl_hi  = i_item.delta;
            n_dd_lo  = i_item.ddelta;
            n_dd_hi  = i_item.ddelta;
        end else begin
            if (i_item.sample < r_raw_lo) n_raw_lo = i_item.sample;
            if (i_item.sample > r_raw_hi) n_raw_hi = i_item.sample;
            if (i_item.delta < r_dl_lo)   n_dl_lo  = i_item.delta;
            if (i_item.delta > r_dl_hi)   n_dl_hi  = i_item.delta;
            if (i_item.ddelta < r_dd_lo)  n_dd_lo  = i_item.ddelta;
            if (i_item.ddelta > r_dd_hi)  n_dd_hi  = i_item.ddelta;
        end

        span_raw = SPAN_W'(n_raw_hi) - SPAN_W'(n_raw_lo);
        span_dl  = SPAN_W'(n_dl_hi) - SPAN_W'(n_dl_lo);
        span_dd  = SPAN_W'(n_dd_hi) - SPAN_W'(n_dd_lo);
        w_raw    = span_width(span_raw);
        w_dl     = span_width(span_dl);
        w_dd     = span_width(span_dd);

        priority if (w_raw <= w_dl && w_raw <= w_dd) begin
            n_bits  = w_raw;
            n_order = ORDER_RAW;
        end else if (w_dl <= w_dd) begin
            n_bits  = w_dl;
            n_order = ORDER_DELTA;
        end else begin
            n_bits  = w_dd;
            n_order = ORDER_DDELTA;
        end
        if (!i_item.last) begin
            n_bits  = '0;
            n_order = ORDER_RAW;
        end

        sum     = {1'b0, r_total} + ((TOTAL_W + 1)'(n_bits) << CHUNK_LOG2);
        n_total = r_total;
        if (pop && i_item.last) begin
            n_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        end

        n_valid = r_valid;
        if (pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_raw_lo   <= n_raw_lo;
            r_raw_hi   <= n_raw_hi;
            r_dl_lo    <= n_dl_lo;
            r_dl_hi    <= n_dl_hi;
            r_dd_lo    <= n_dd_lo;
            r_dd_hi    <= n_dd_hi;
            r_delta_o  <= sat8(DDELTA_W'(i_item.delta));
            r_ddelta_o <= sat8(i_item.ddelta);
            r_end      <= i_item.last;
            r_bits     <= n_bits;
            r_order    <= n_order;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            r_total <= n_total;
            r_valid <= n_valid;
        end
    end

    assign o_valid       = r_valid;
    assign o_delta_out   = r_delta_o;
    assign o_ddelta_out  = r_ddelta_o;
    assign o_chunk_end   = r_end;
    assign o_chunk_bits  = r_bits;
    assign o_chunk_order = r_order;
    assign o_total_bits  = r_total;

    `CDOBE_ASSERT(a_open_chunk_zero, i_clk, i_rst_n, !(r_valid && !r_end) || (r_bits == '0 && r_order == ORDER_RAW), "open chunk reports bits")
    `CDOBE_ASSERT(a_total_monotone, i_clk, i_rst_n, !$past(i_rst_n) || (r_total >= $past(r_total)), "bit total decreased")
    `CDOBE_ASSERT_NEXT(a_total_only_on_end, i_clk, i_rst_n, !(pop && i_item.last), r_total == $past(r_total), "bit total moved mid chunk")

endmodule

`default_nettype wire

[hdl/chunked_delta_order_bit_estimator_unit.sv]
// A sample is registered in the queue, then in the back section's output
// register. Throughput: one sample per cycle unless the output stalls; the
// range update, width select and 32-bit saturating add are combinational.
// A two-entry queue lets the front keep accepting until it fills.
// Reset: synchronous active low; clears history, chunk position and total.
// ----------------------------------------------------------------------------
// chunked_delta_order_bit_estimator_unit
// Per-sample first and second differences with per-chunk order selection.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_delta_order_bit_estimator_unit #(
    parameter int CHUNK_LOG2 = cdobe_pkg::CHUNK_LOG2_DEFAULT
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic signed [cdobe_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic signed [cdobe_pkg::SAMPLE_W-1:0]      o_delta_out,
    output logic signed [cdobe_pkg::SAMPLE_W-1:0]      o_ddelta_out,
    output logic                                       o_chunk_end,
    output logic [cdobe_pkg::BITS_W-1:0]               o_chunk_bits,
    output logic [1:0]                                 o_chunk_order,
    output logic [cdobe_pkg::TOTAL_W-1:0]              o_total_bits
);
    import cdobe_pkg::*;

    t_front_item front_item;
    logic        front_valid;
    logic        front_ready;
    t_front_item back_item;
    logic        back_valid;
    logic        back_ready;

    cdobe_front #(
        .CHUNK_LOG2 (CHUNK_LOG2)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (i_sample),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .o_item       (front_item),
        .o_item_valid (front_valid),
        .i_item_ready (front_ready)
    );

    cdobe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (front_item),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .o_item       (back_item),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready)
    );

    cdobe_back #(
        .CHUNK_LOG2 (CHUNK_LOG2)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (back_item),
        .i_item_valid  (back_valid),
        .o_item_ready  (back_ready),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_delta_out   (o_delta_out),
        .o_ddelta_out  (o_ddelta_out),
        .o_chunk_end   (o_chunk_end),
        .o_chunk_bits  (o_chunk_bits),
        .o_chunk_order (o_chunk_order),
        .o_total_bits  (o_total_bits)
    );

endmodule

`default_nettype wire

[tb/sv/delta_order_scoreboard_pkg.sv]
// ----------------------------------------------------------------------------
// Delta order scoreboard
// Predicts the difference outputs and per-chunk order choice of each sample
// request and compares every returned result against the oldest prediction.
// ----------------------------------------------------------------------------
package delta_order_scoreboard_pkg;

    import cdobe_pkg::*;

    localparam int CHUNK_LOG2 = 4;
    localparam int CHUNK_SIZE = 1 << CHUNK_LOG2;
    localparam int MAX_PRINTED = 20;

    typedef struct {
        logic signed [SAMPLE_W-1:0] delta;
        logic signed [SAMPLE_W-1:0] ddelta;
        logic                       chunk_end;
        logic [BITS_W-1:0]          bits;
        t_order                     order;
        logic [TOTAL_W-1:0]         total;
    } sample_result_t;

    class delta_order_scoreboard;

        sample_result_t            pending_q[$];
        logic signed [SAMPLE_W-1:0] prev_sample;
        logic signed [DELTA_W-1:0]  prev_delta;
        logic [CHUNK_LOG2-1:0]      chunk_pos;
        logic signed [DDELTA_W-1:0] span_lo[3];
        logic signed [DDELTA_W-1:0] span_hi[3];
        logic [TOTAL_W-1:0]         total;
        int                         errors;
        int                         checked;
        int                         chunks;
        int                         order_hits[3];
        int                         clipped;

        function new();
            prev_sample = '0;
            prev_delta  = '0;
            chunk_pos   = '0;
            total       = '0;
            errors      = 0;
            checked     = 0;
            chunks      = 0;
            clipped     = 0;
            for (int i = 0; i < 3; i++) begin
                span_lo[i]    = '0;
                span_hi[i]    = '0;
                order_hits[i] = 0;
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        static function logic signed [SAMPLE_W-1:0] clip8(int v);
            if (v < SAMPLE_MIN) begin
                return SAMPLE_W'(SAMPLE_MIN);
            end
            if (v > SAMPLE_MAX) begin
                return SAMPLE_W'(SAMPLE_MAX);
            end
            return SAMPLE_W'(v);
        endfunction

        static function int width_of(int lo, int hi);
            int w;
            w = 0;
            while ((1 << w) < (hi - lo + 1)) begin
                w++;
            end
            return w;
        endfunction

        function void note_request(logic signed [SAMPLE_W-1:0] s);
            int             cur;
            int             d;
            int             dd;
            int             vals[3];
            int             w[3];
            longint         sum;
            sample_result_t r;
            cur = int'(s);
            d   = cur - int'(prev_sample);
            dd  = d - int'(prev_delta);
            vals[0] = cur;
            vals[1] = d;
            vals[2] = dd;
            for (int i = 0; i < 3; i++) begin
                if (chunk_pos == 0) begin
                    span_lo[i] = DDELTA_W'(vals[i]);
                    span_hi[i] = DDELTA_W'(vals[i]);
                end else begin
                    if (vals[i] < int'(span_lo[i])) span_lo[i] = DDELTA_W'(vals[i]);
                    if (vals[i] > int'(span_hi[i])) span_hi[i] = DDELTA_W'(vals[i]);
                end
            end
            r.delta     = clip8(d);
            r.ddelta    = clip8(dd);
            r.chunk_end = (chunk_pos == CHUNK_SIZE - 1);
            r.bits      = '0;
            r.order     = ORDER_RAW;
            if (r.chunk_end) begin
                for (int i = 0; i < 3; i++) begin
                    w[i] = width_of(int'(span_lo[i]), int'(span_hi[i]));
                end
                if (w[0] <= w[1] && w[0] <= w[2]) begin
                    r.bits  = BITS_W'(w[0]);
                    r.order = ORDER_RAW;
                end else if (w[1] <= w[2]) begin
                    r.bits  = BITS_W'(w[1]);
                    r.order = ORDER_DELTA;
                end else begin
                    r.bits  = BITS_W'(w[2]);
                    r.order = ORDER_DDELTA;
                end
                sum   = longint'(total) + (longint'(r.bits) << CHUNK_LOG2);
                total = (sum > longint'(32'hFFFF_FFFF)) ? '1 : TOTAL_W'(sum);
                chunks++;
                order_hits[int'(r.order)]++;
            end
            r.total = total;
            if (d < SAMPLE_MIN || d > SAMPLE_MAX || dd < SAMPLE_MIN || dd > SAMPLE_MAX) begin
                clipped++;
            end
            prev_sample = s;
            prev_delta  = DELTA_W'(d);
            chunk_pos   = chunk_pos + 1'b1;
            pending_q.push_back(r);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_PRINTED) begin
                $display("[%0t] MISMATCH %0d: %s", $realtime, errors, what);
            end
        endtask

        task check_result(
            logic signed [SAMPLE_W-1:0] d,
            logic signed [SAMPLE_W-1:0] dd,
            logic                       ce,
            logic [BITS_W-1:0]          bits,
            logic [1:0]                 ord,
            logic [TOTAL_W-1:0]         tot
        );
            sample_result_t e;
            if (pending_q.size() == 0) begin
                report_mismatch("result with no request pending");
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (d !== e.delta) begin
                report_mismatch($sformatf("result %0d delta %0d, want %0d",
                    checked, d, e.delta));
            end
            if (dd !== e.ddelta) begin
                report_mismatch($sformatf("result %0d ddelta %0d, want %0d",
                    checked, dd, e.ddelta));
            end
            if (ce !== e.chunk_end) begin
                report_mismatch($sformatf("result %0d chunk_end %b, want %b",
                    checked, ce, e.chunk_end));
            end
            if (bits !== e.bits) begin
                report_mismatch($sformatf("result %0d chunk_bits %0d, want %0d",
                    checked, bits, e.bits));
            end
            if (ord !== e.order) begin
                report_mismatch($sformatf("result %0d chunk_order %0d, want %0d",
                    checked, ord, e.order));
            end
            if (tot !== e.total) begin
                report_mismatch($sformatf("result %0d total_bits %0d, want %0d",
                    checked, tot, e.total));
            end
        endtask

    endclass

endpackage

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Delta order estimator testbench
// Streams directed and pattern-shaped random samples through the estimator
// under varying source and sink stalls, and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cdobe_pkg::*;
    import delta_order_scoreboard_pkg::*;

    localparam int PHASE_ITEMS = 633;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [SAMPLE_W-1:0] o_delta_out;
    logic signed [SAMPLE_W-1:0] o_ddelta_out;
    logic                       o_chunk_end;
    logic [BITS_W-1:0]          o_chunk_bits;
    logic [1:0]                 o_chunk_order;
    logic [TOTAL_W-1:0]         o_total_bits;

    int tx_idle_pct;
    int rx_idle_pct;
    int sent;

    delta_order_scoreboard sb;

    chunked_delta_order_bit_estimator_unit #(
        .CHUNK_LOG2(CHUNK_LOG2)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_delta_out  (o_delta_out),
        .o_ddelta_out (o_ddelta_out),
        .o_chunk_end  (o_chunk_end),
        .o_chunk_bits (o_chunk_bits),
        .o_chunk_order(o_chunk_order),
        .o_total_bits (o_total_bits)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_delta_out, o_ddelta_out, o_chunk_end, o_chunk_bits,
                o_chunk_order, o_total_bits);
        end
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= v;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(v);
        sent++;
    endtask

    task automatic send_pattern();
        int mode;
        int len;
        int base;
        int step;
        int amp;
        int sgn;
        int v;
        int k;
        logic signed [SAMPLE_W-1:0] extremes[6];
        extremes = '{-8'sd128, 8'sd127, -8'sd127, 8'sd126, 8'sd0, -8'sd1};
        mode = $urandom_range(9);
        len  = $urandom_range(32, 12);
        base = $urandom_range(255) - 128;
        step = $urandom_range(16) - 8;
        amp  = $urandom_range(3);
        sgn  = $urandom_range(1) ? 1 : -1;
        for (k = 0; k < len; k++) begin
            case (mode)
                0, 1: begin
                    v = $urandom_range(255);
                end
                2: begin
                    v = base;
                end
                3, 4: begin
                    v = base + step * k;
                end
                5, 6: begin
                    v = (sgn > 0) ? (-128 + amp + (k % 16) * (k % 16))
                                  : (127 - amp - (k % 16) * (k % 16));
                end
                7, 8: begin
                    v = base + $urandom_range(2 * amp) - amp;
                    if (v < SAMPLE_MIN) v = SAMPLE_MIN;
                    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
                end
                default: begin
                    v = extremes[$urandom_range(5)];
                end
            endcase
            send_sample(SAMPLE_W'(v));
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct);
        int stop_at;
        stop_at     = sent + PHASE_ITEMS;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (sent < stop_at) begin
            send_pattern();
        end
    endtask

    initial begin
        logic signed [SAMPLE_W-1:0] swings[9];
        swings = '{8'sd127, -8'sd128, 8'sd127, -8'sd128, -8'sd128,
                   8'sd127, 8'sd127, 8'sd0, -8'sd1};
        sb          = new();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_sample    = '0;
        i_ready     = 1'b0;
        tx_idle_pct = 30;
        rx_idle_pct = 78;
        sent        = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // flat opening chunk, then full-scale swings
        for (int i = 0; i < CHUNK_SIZE; i++) begin
            send_sample('0);
        end
        foreach (swings[i]) begin
            send_sample(swings[i]);
        end
        run_phase(30, 78);
        run_phase(78, 30);
        run_phase(0, 0);
        i_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        $display("Ran %0d samples, %0d results checked, %0d with clipped differences.",
            sent, sb.checked, sb.clipped);
        $display("Closed %0d chunks: raw %0d, delta %0d, ddelta %0d; final total %0d.",
            sb.chunks, sb.order_hits[0], sb.order_hits[1], sb.order_hits[2], sb.total);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", sb.pending());
        $display("Verification failed");
        $finish;
    end

endmodule

[chunked_delta_order_bit_estimator_unit.f]
+incdir+hdl
hdl/cdobe_pkg.sv
hdl/cdobe_front.sv
hdl/cdobe_queue.sv
hdl/cdobe_back.sv
hdl/chunked_delta_order_bit_estimator_unit.sv
tb/sv/delta_order_scoreboard_pkg.sv
tb/sv/testbench.sv
